/* rtl/tws_pkg.sv */
`default_nettype none

package tws_pkg;

  // Width and reset value of the half period register.
  localparam int unsigned CFG_W = 16;
  localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 16'd5;

  // Operation codes of a byte command.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Bit position of the last bit in a byte.
  localparam logic [2:0] LAST_BIT = 3'd7;

  // Phases of the serial bus sequencer.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_HIGH  = 3'd2,
    PH_LOW   = 3'd3,
    PH_STOP1 = 3'd4,
    PH_STOP2 = 3'd5
  } phase_t;

  // Levels of the serial pins.
  typedef struct packed {
    logic drv;
    logic dout;
    logic stb;
    logic clk;
  } pins_t;

  localparam pins_t PINS_RESET = '{drv: 1'b0, dout: 1'b1, stb: 1'b1, clk: 1'b1};

  // One input tick.
  typedef struct packed {
    logic       cmd_valid;
    logic       operation;
    logic [7:0] write_value;
    logic       begin_frame;
    logic       end_frame;
    logic       dat_pin_in;
  } in_t;

  // One result tick.
  typedef struct packed {
    logic       clk_pin;
    logic       stb_pin;
    logic       dat_pin_out;
    logic       dat_drive;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_value;
  } out_t;

endpackage

`default_nettype wire

/* rtl/tws_seq.sv */
`default_nettype none

module tws_seq #(
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step_en,
  input  wire logic                      cfg_we,
  input  wire logic [tws_pkg::CFG_W-1:0] cfg_data,
  input  wire tws_pkg::in_t              in_data,
  output tws_pkg::out_t                  result
);
  import tws_pkg::*;

  logic [CFG_W-1:0]      half_r;
  phase_t                phase_r, phase_nxt;
  logic [2:0]            bit_r, bit_nxt;
  logic [WAIT_WIDTH-1:0] wait_r, wait_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic                  reading_r, reading_nxt;
  logic                  stop_r, stop_nxt;
  pins_t                 pins_r, pins_nxt;

  logic [WAIT_WIDTH-1:0] load_raw;
  logic [WAIT_WIDTH-1:0] load_val;
  logic                  busy;
  logic                  expired;
  logic                  go_high;
  logic                  load;

  // Fit the half period to the wait counter width.
  generate
    if (WAIT_WIDTH == CFG_W) begin : g_same
      assign load_raw = half_r;
    end else if (WAIT_WIDTH > CFG_W) begin : g_wide
      assign load_raw = {{(WAIT_WIDTH-CFG_W){1'b0}}, half_r};
    end else begin : g_narrow
      assign load_raw = half_r[WAIT_WIDTH-1:0];
    end
  endgenerate

  // A zero half period counts as one tick.
  assign load_val = (load_raw == '0) ? {{(WAIT_WIDTH-1){1'b0}}, 1'b1} : load_raw;

  assign busy    = (phase_r != PH_IDLE);
  assign expired = busy && (wait_r <= {{(WAIT_WIDTH-1){1'b0}}, 1'b1});

  // Next state of the sequencer for this tick.
  always_comb begin
    phase_nxt   = phase_r;
    bit_nxt     = bit_r;
    wait_nxt    = wait_r;
    shift_nxt   = shift_r;
    reading_nxt = reading_r;
    stop_nxt    = stop_r;
    pins_nxt    = pins_r;
    go_high     = 1'b0;
    load        = 1'b0;

    if (!busy) begin
      if (in_data.cmd_valid) begin
        reading_nxt = (in_data.operation == OP_READ);
        shift_nxt   = (in_data.operation == OP_READ) ? 8'h00 : in_data.write_value;
        stop_nxt    = in_data.end_frame;
        bit_nxt     = 3'd0;
        if (in_data.begin_frame) begin
          pins_nxt.stb = 1'b0;
          phase_nxt    = PH_START;
          load         = 1'b1;
        end else begin
          go_high = 1'b1;
        end
      end
    end else if (expired) begin
      wait_nxt = '0;
    end else begin
      wait_nxt = wait_r - {{(WAIT_WIDTH-1){1'b0}}, 1'b1};
    end

    if (expired) begin
      unique case (phase_r)
        PH_START: begin
          go_high = 1'b1;
        end
        PH_HIGH: begin
          if (reading_r) begin
            shift_nxt = {in_data.dat_pin_in, shift_r[7:1]};
          end
          pins_nxt.clk = 1'b0;
          phase_nxt    = PH_LOW;
          load         = 1'b1;
        end
        PH_LOW: begin
          if (bit_r == LAST_BIT) begin
            bit_nxt = 3'd0;
            if (stop_r) begin
              pins_nxt.clk = 1'b1;
              phase_nxt    = PH_STOP1;
              load         = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end else begin
            bit_nxt = bit_r + 3'd1;
            if (!reading_r) begin
              shift_nxt = {1'b0, shift_r[7:1]};
            end
            go_high = 1'b1;
          end
        end
        PH_STOP1: begin
          pins_nxt.stb  = 1'b1;
          pins_nxt.dout = 1'b1;
          pins_nxt.drv  = 1'b0;
          phase_nxt     = PH_STOP2;
          load          = 1'b1;
        end
        PH_STOP2: begin
          stop_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // Enter the clock-high half of a bit.
    if (go_high) begin
      pins_nxt.dout = reading_nxt ? 1'b1 : shift_nxt[0];
      pins_nxt.drv  = !reading_nxt;
      pins_nxt.clk  = 1'b1;
      phase_nxt     = PH_HIGH;
      load          = 1'b1;
    end

    if (load) begin
      wait_nxt = load_val;
    end
  end

  // Result of this tick: pin levels after the action and read completion.
  always_comb begin
    result.clk_pin     = pins_nxt.clk;
    result.stb_pin     = pins_nxt.stb;
    result.dat_pin_out = pins_nxt.dout;
    result.dat_drive   = pins_nxt.drv;
    result.busy_res    = busy;
    result.read_valid  = expired && (phase_r == PH_LOW) && (bit_r == LAST_BIT) && reading_r;
    result.read_value  = result.read_valid ? shift_r : 8'h00;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_r <= cfg_data;
    end
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_r     <= 3'd0;
      wait_r    <= '0;
      shift_r   <= 8'h00;
      reading_r <= 1'b0;
      stop_r    <= 1'b0;
      pins_r    <= PINS_RESET;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      bit_r     <= bit_nxt;
      wait_r    <= wait_nxt;
      shift_r   <= shift_nxt;
      reading_r <= reading_nxt;
      stop_r    <= stop_nxt;
      pins_r    <= pins_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tws_out_reg.sv */
`default_nettype none

module tws_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire tws_pkg::out_t load_data,
  output logic               can_load,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tws_pkg::out_t      out_data
);
  import tws_pkg::*;

  logic valid_r;
  out_t data_r;

  // A new result may enter when the register is empty or is being drained.
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Valid flag of the held result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/three_wire_serial_master_core.sv */
// Three-wire serial master, one request per tick of the half period timer.
// The result of a request is registered and shown in the cycle after it is accepted.
// Throughput: one request per cycle; the sequencer state is one register stage.
// A full result register only stalls input while its result is not taken.
// Reset (synchronous, active low) sets clock and strobe high, releases data,
// returns the sequencer to idle and loads a half period of 5 ticks.
`default_nettype none

module three_wire_serial_master_core #(
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire tws_pkg::in_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tws_pkg::out_t                  out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [tws_pkg::CFG_W-1:0] cfg_data
);
  import tws_pkg::*;

  out_t step_result;
  logic step_en;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign step_en   = in_valid && in_ready;

  // Bus sequencer.
  tws_seq #(
    .WAIT_WIDTH(WAIT_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .in_data (in_data),
    .result  (step_result)
  );

  // Result register.
  tws_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step_en),
    .load_data(step_result),
    .can_load (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* rtl/tws_checker.sv */
`default_nettype none

module tws_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire tws_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire tws_pkg::out_t out_data
);
  import tws_pkg::*;

  // An accepted request always produces a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // A stalled result holds its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An empty result register never blocks input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while result register is empty");

  // Read data is zero unless a read completes, and a completed read has data released.
  a_read_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.read_valid ? !out_data.dat_drive : (out_data.read_value == 8'h00)))
    else $error("read result inconsistent");

  // An accepted request with no command, while the shown result has the bus idle, gives no read in its result.
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.cmd_valid && out_valid && !out_data.busy_res
      && out_data.stb_pin && out_data.clk_pin
    |=> !out_data.read_valid)
    else $error("idle tick produced a read");

endmodule

bind three_wire_serial_master_core tws_checker u_tws_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
